// ===== design/sdepq_pkg.sv =====
// Package for the sorted double-ended priority queue: payload types and codes.
`timescale 1ns / 1ps

package sdepq_pkg;

  // Operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELMIN = 2'd1;
  localparam logic [1:0] FUNC_DELMAX = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // One stored entry
  typedef struct packed {
    logic signed [15:0] key;
    logic        [7:0]  tag;
  } entry_t;

  // Input transaction
  typedef struct packed {
    logic        [1:0]  func;
    logic signed [15:0] key;
    logic        [7:0]  tag;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic        [1:0]  status;
    logic signed [15:0] popped_key;
    logic        [7:0]  popped_tag;
    logic signed [15:0] min_key;
    logic        [7:0]  min_tag;
    logic signed [15:0] max_key;
    logic        [7:0]  max_tag;
    logic        [4:0]  count;
    logic               empty_res;
    logic               full_res;
  } out_t;

  // Broadcast control to every cell
  typedef struct packed {
    logic       en;
    logic [1:0] func;
  } cell_ctrl_t;

endpackage

// ===== design/sorted_double_ended_priority_queue.sv =====
// Top level of the sorted double-ended priority queue.
`timescale 1ns / 1ps

// A row of CAPACITY cells keeps the entries sorted by ascending signed key;
// a new key lands before equal keys. Each transaction is insert, delete
// minimum, delete maximum or clear, and yields one result with the popped
// entry, the new minimum and maximum, the count and a status. The cell row
// updates at the accepting edge. The next cycle picks the minimum and maximum
// from the updated row into the output register. The result is presented
// in the output state that follows the calculation state, and is held until
// taken. Input is stalled from acceptance until the result is taken.

module sorted_double_ended_priority_queue
  import sdepq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [1:0]          status_q, status_d;
  entry_t              popped_q, popped_d;
  out_t                out_q, out_d;

  entry_t              ent [CAPACITY];
  logic [CAPACITY-1:0] vld;
  logic [CAPACITY-1:0] less;
  logic [CAPACITY-1:0] last;
  entry_t              max_sel;
  entry_t              min_sel;
  entry_t              new_entry;
  cell_ctrl_t          ctrl;
  logic                in_acc;
  logic                full;
  logic                op_ok;
  logic [CNT_W+4:0]    count_ext;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign new_entry  = '{key: in_data_i.key, tag: in_data_i.tag};

  // Decide whether the operation changes the row
  always_comb begin
    case (in_data_i.func)
      FUNC_INSERT: op_ok = !full;
      FUNC_DELMIN: op_ok = vld[0];
      FUNC_DELMAX: op_ok = vld[0];
      default:     op_ok = 1'b1;
    endcase
  end

  assign ctrl = '{en: in_acc && op_ok, func: in_data_i.func};

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_v, left_l, right_v;

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_v = 1'b1;
      assign left_l = 1'b1;
    end else begin : g_mid_l
      assign left_e = ent[i-1];
      assign left_v = vld[i-1];
      assign left_l = less[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = '0;
      assign right_v = 1'b0;
      assign last[i] = vld[i];
    end else begin : g_mid_r
      assign right_e = ent[i+1];
      assign right_v = vld[i+1];
      assign last[i] = vld[i] && !vld[i+1];
    end

    sdepq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_i         (new_entry),
      .left_i        (left_e),
      .left_valid_i  (left_v),
      .left_less_i   (left_l),
      .right_i       (right_e),
      .right_valid_i (right_v),
      .entry_o       (ent[i]),
      .valid_o       (vld[i]),
      .less_o        (less[i])
    );
  end

  // Highest valid cell, one-hot AND-OR select; zero when empty
  always_comb begin
    max_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      max_sel = max_sel | (last[i] ? ent[i] : '0);
    end
  end

  assign min_sel = vld[0] ? ent[0] : '0;

  // Count, status and popped entry at acceptance
  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    popped_d = popped_q;
    if (in_acc) begin
      status_d = STATUS_OK;
      popped_d = '0;
      case (in_data_i.func)
        FUNC_INSERT: begin
          if (full) status_d = STATUS_FULL;
          else      count_d  = count_q + 1'b1;
        end
        FUNC_DELMIN: begin
          if (!vld[0]) begin
            status_d = STATUS_EMPTY;
          end else begin
            popped_d = ent[0];
            count_d  = count_q - 1'b1;
          end
        end
        FUNC_DELMAX: begin
          if (!vld[0]) begin
            status_d = STATUS_EMPTY;
          end else begin
            popped_d = max_sel;
            count_d  = count_q - 1'b1;
          end
        end
        FUNC_CLEAR: begin
          count_d = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  assign count_ext = {5'b0, count_q};

  // Result assembly from the updated row
  always_comb begin
    out_d            = out_q;
    out_d.status     = status_q;
    out_d.popped_key = popped_q.key;
    out_d.popped_tag = popped_q.tag;
    out_d.min_key    = min_sel.key;
    out_d.min_tag    = min_sel.tag;
    out_d.max_key    = max_sel.key;
    out_d.max_tag    = max_sel.tag;
    out_d.count      = count_ext[4:0];
    out_d.empty_res  = !vld[0];
    out_d.full_res   = full;
  end

  // Transaction sequencing
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_CALC;
      ST_CALC: state_d = ST_OUT;
      ST_OUT:  if (!out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    popped_q <= popped_d;
    if (state_q == ST_CALC) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o  = out_q;

endmodule

// ===== design/sdepq_cell.sv =====
// One cell of the sorted chain: holds one entry and shifts with its neighbors.
`timescale 1ns / 1ps

module sdepq_cell
  import sdepq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     new_i,
  input  entry_t     left_i,
  input  logic       left_valid_i,
  input  logic       left_less_i,
  input  entry_t     right_i,
  input  logic       right_valid_i,
  output entry_t     entry_o,
  output logic       valid_o,
  output logic       less_o
);

  entry_t entry_q, entry_d;
  logic   valid_q, valid_d;

  // Valid cells form a sorted prefix, so less flags form a prefix too
  assign less_o  = valid_q && (entry_q.key < new_i.key);
  assign entry_o = entry_q;
  assign valid_o = valid_q;

  // Next entry: keep, take new, or take a neighbor
  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (ctrl_i.en) begin
      case (ctrl_i.func)
        FUNC_INSERT: begin
          if (!less_o) begin
            entry_d = left_less_i ? new_i : left_i;
            valid_d = valid_q | left_valid_i;
          end
        end
        FUNC_DELMIN: begin
          entry_d = right_i;
          valid_d = right_valid_i;
        end
        FUNC_DELMAX: begin
          valid_d = right_valid_i;
        end
        FUNC_CLEAR: begin
          valid_d = 1'b0;
        end
        default: begin
          valid_d = valid_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== tb/sorted_double_ended_priority_queue_tb.sv =====
// Testbench for the sorted double-ended priority queue: shadow queue, directed and random ops.
`timescale 1ns / 1ps

module sorted_double_ended_priority_queue_tb;
  import sdepq_pkg::*;

  localparam int CAPACITY       = 16;
  localparam int RANDOM_OPS     = 1526;
  localparam int PAUSE_AT       = 700;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND} op_mix_e;

  // One row of the directed table; res is used only when typed is set
  typedef struct {
    in_t  op;
    bit   typed;
    out_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  // Shadow copy of the sorted entries
  logic signed [15:0] shadow_key [CAPACITY];
  logic [7:0]         shadow_tag [CAPACITY];
  int                 shadow_count = 0;

  out_t     pending_results[$];
  dir_row_t dir_rows[$];

  int  n_fail = 0;
  int  n_checked = 0;
  int  n_rejects = 0;
  int  n_empty_dels = 0;
  int  n_full_seen = 0;
  int  peak_count = 0;
  int  func_seen[4] = '{0, 0, 0, 0};
  int  idle_cycles = 0;
  int  sink_hold = 0;
  bit  steady = 1'b0;

  sorted_double_ended_priority_queue #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic in_t mk_op(logic [1:0] f, logic [15:0] k, logic [7:0] t);
    in_t op;
    op.func = f;
    op.key  = k;
    op.tag  = t;
    return op;
  endfunction

  function automatic out_t mk_res(logic [1:0] st, logic [15:0] mnk, logic [7:0] mnt,
                                  logic [15:0] mxk, logic [7:0] mxt, logic [4:0] cnt,
                                  logic full);
    out_t r;
    r = '0;
    r.status    = st;
    r.min_key   = mnk;
    r.min_tag   = mnt;
    r.max_key   = mxk;
    r.max_tag   = mxt;
    r.count     = cnt;
    r.empty_res = (cnt == 0);
    r.full_res  = full;
    return r;
  endfunction

  // Apply one op to the shadow queue and return the result it should give
  function automatic out_t shadow_apply(in_t op);
    out_t r;
    int   pos;
    int   i;
    r = '0;
    r.status = STATUS_OK;
    func_seen[op.func]++;
    case (op.func)
      FUNC_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = STATUS_FULL;
          n_rejects++;
        end else begin
          // new key lands ahead of equal keys
          pos = 0;
          while (pos < shadow_count && $signed(shadow_key[pos]) < $signed(op.key))
            pos++;
          for (i = shadow_count; i > pos; i--) begin
            shadow_key[i] = shadow_key[i-1];
            shadow_tag[i] = shadow_tag[i-1];
          end
          shadow_key[pos] = op.key;
          shadow_tag[pos] = op.tag;
          shadow_count++;
        end
      end
      FUNC_DELMIN: begin
        if (shadow_count == 0) begin
          r.status = STATUS_EMPTY;
          n_empty_dels++;
        end else begin
          r.popped_key = shadow_key[0];
          r.popped_tag = shadow_tag[0];
          for (i = 1; i < shadow_count; i++) begin
            shadow_key[i-1] = shadow_key[i];
            shadow_tag[i-1] = shadow_tag[i];
          end
          shadow_count--;
        end
      end
      FUNC_DELMAX: begin
        if (shadow_count == 0) begin
          r.status = STATUS_EMPTY;
          n_empty_dels++;
        end else begin
          shadow_count--;
          r.popped_key = shadow_key[shadow_count];
          r.popped_tag = shadow_tag[shadow_count];
        end
      end
      default: begin
        // clear drops everything without popping
        shadow_count = 0;
      end
    endcase
    if (shadow_count > 0) begin
      r.min_key = shadow_key[0];
      r.min_tag = shadow_tag[0];
      r.max_key = shadow_key[shadow_count-1];
      r.max_tag = shadow_tag[shadow_count-1];
    end
    r.count     = shadow_count[4:0];
    r.empty_res = (shadow_count == 0);
    r.full_res  = (shadow_count == CAPACITY);
    if (shadow_count > peak_count) peak_count = shadow_count;
    if (shadow_count == CAPACITY) n_full_seen++;
    return r;
  endfunction

  // Sender gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [1:0] pick_func(op_mix_e mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 78) return FUNC_INSERT;
        if (r < 88) return FUNC_DELMIN;
        if (r < 98) return FUNC_DELMAX;
        return FUNC_CLEAR;
      end
      MIX_DRAIN: begin
        if (r < 22) return FUNC_INSERT;
        if (r < 60) return FUNC_DELMIN;
        if (r < 98) return FUNC_DELMAX;
        return FUNC_CLEAR;
      end
      default: begin
        if (r < 45) return FUNC_INSERT;
        if (r < 70) return FUNC_DELMIN;
        if (r < 95) return FUNC_DELMAX;
        return FUNC_CLEAR;
      end
    endcase
  endfunction

  // Keys: clustered values for ties, extremes, or anything at all
  function automatic logic [15:0] pick_key();
    int r;
    logic [15:0] k;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      k = 16'(($urandom_range(0, 7) - 4) * 256);
    end else if (r < 50) begin
      case ($urandom_range(0, 3))
        0:       k = 16'h8000;
        1:       k = 16'h7FFF;
        2:       k = 16'h0000;
        default: k = 16'hFFFF;
      endcase
    end else begin
      k = 16'($urandom);
    end
    return k;
  endfunction

  // Present one transaction, hold it until taken, record its expected result
  task automatic send_op(in_t op, bit typed, out_t typed_res);
    int   gap;
    out_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= op;
    do @(posedge clk); while (in_stall_o);
    pred = shadow_apply(op);
    pending_results.push_back(typed ? typed_res : pred);
    @(negedge clk);
  endtask

  task automatic compare_result(out_t got, out_t exp);
    if (got.status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, got.status);
      n_fail++;
    end
    if (got.popped_key !== exp.popped_key) begin
      $error("popped_key: expected %0d, got %0d", $signed(exp.popped_key),
             $signed(got.popped_key));
      n_fail++;
    end
    if (got.popped_tag !== exp.popped_tag) begin
      $error("popped_tag: expected %0d, got %0d", exp.popped_tag, got.popped_tag);
      n_fail++;
    end
    if (got.min_key !== exp.min_key) begin
      $error("min_key: expected %0d, got %0d", $signed(exp.min_key), $signed(got.min_key));
      n_fail++;
    end
    if (got.min_tag !== exp.min_tag) begin
      $error("min_tag: expected %0d, got %0d", exp.min_tag, got.min_tag);
      n_fail++;
    end
    if (got.max_key !== exp.max_key) begin
      $error("max_key: expected %0d, got %0d", $signed(exp.max_key), $signed(got.max_key));
      n_fail++;
    end
    if (got.max_tag !== exp.max_tag) begin
      $error("max_tag: expected %0d, got %0d", exp.max_tag, got.max_tag);
      n_fail++;
    end
    if (got.count !== exp.count) begin
      $error("count: expected %0d, got %0d", exp.count, got.count);
      n_fail++;
    end
    if (got.empty_res !== exp.empty_res) begin
      $error("empty_res: expected %0d, got %0d", exp.empty_res, got.empty_res);
      n_fail++;
    end
    if (got.full_res !== exp.full_res) begin
      $error("full_res: expected %0d, got %0d", exp.full_res, got.full_res);
      n_fail++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation pending");
        n_fail++;
      end else begin
        compare_result(out_data_o, pending_results.pop_front());
        n_checked++;
      end
    end
  end

  // Receiver stall: runs of random length, quiet during steady stretches
  always @(negedge clk) begin
    int r;
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else if (steady) begin
      out_stall_i <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall_i <= 1'b0;
        sink_hold   <= $urandom_range(0, 4);
      end else if (r < 95) begin
        out_stall_i <= 1'b1;
        sink_hold   <= $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        sink_hold   <= $urandom_range(8, 25);
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results pending", pending_results.size());
        $display("sorted_double_ended_priority_queue verification failed");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    op_mix_e mix;
    int      burst_left;
    in_t     op;
    out_t    none;

    none = '0;

    // directed table: empty ops, extremes, ties, fill to full, reject, delete from both ends, clear
    dir_rows.push_back('{mk_op(FUNC_DELMIN, 16'hFFFF, 8'hFF), 1'b1,
                         mk_res(STATUS_EMPTY, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_op(FUNC_DELMAX, 16'hFFFF, 8'hFF), 1'b1,
                         mk_res(STATUS_EMPTY, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_op(FUNC_CLEAR, 16'h0000, 8'h00), 1'b1,
                         mk_res(STATUS_OK, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_op(FUNC_INSERT, 16'h7FFF, 8'hFF), 1'b1,
                         mk_res(STATUS_OK, 16'h7FFF, 8'hFF, 16'h7FFF, 8'hFF, 1, 0)});
    dir_rows.push_back('{mk_op(FUNC_INSERT, 16'h8000, 8'h00), 1'b1,
                         mk_res(STATUS_OK, 16'h8000, 8'h00, 16'h7FFF, 8'hFF, 2, 0)});
    dir_rows.push_back('{mk_op(FUNC_INSERT, 16'h0000, 8'h55), 1'b0, none});
    dir_rows.push_back('{mk_op(FUNC_INSERT, 16'h0000, 8'hAA), 1'b0, none});
    dir_rows.push_back('{mk_op(FUNC_INSERT, 16'h0100, 8'h01), 1'b0, none});
    dir_rows.push_back('{mk_op(FUNC_INSERT, 16'hFF00, 8'h02), 1'b0, none});
    dir_rows.push_back('{mk_op(FUNC_INSERT, 16'h0080, 8'h03), 1'b0, none});
    dir_rows.push_back('{mk_op(FUNC_INSERT, 16'hFFFF, 8'h04), 1'b0, none});
    dir_rows.push_back('{mk_op(FUNC_INSERT, 16'h0001, 8'h05), 1'b0, none});
    dir_rows.push_back('{mk_op(FUNC_INSERT, 16'h7FFE, 8'h06), 1'b0, none});
    dir_rows.push_back('{mk_op(FUNC_INSERT, 16'h8001, 8'h07), 1'b0, none});
    dir_rows.push_back('{mk_op(FUNC_INSERT, 16'h0100, 8'h08), 1'b0, none});
    dir_rows.push_back('{mk_op(FUNC_INSERT, 16'hFF00, 8'h09), 1'b0, none});
    dir_rows.push_back('{mk_op(FUNC_INSERT, 16'h4000, 8'h0A), 1'b0, none});
    dir_rows.push_back('{mk_op(FUNC_INSERT, 16'hC000, 8'h0B), 1'b0, none});
    dir_rows.push_back('{mk_op(FUNC_INSERT, 16'h5A5A, 8'hC3), 1'b0, none});
    dir_rows.push_back('{mk_op(FUNC_INSERT, 16'h1234, 8'h3C), 1'b1,
                         mk_res(STATUS_FULL, 16'h8000, 8'h00, 16'h7FFF, 8'hFF, 16, 1)});
    dir_rows.push_back('{mk_op(FUNC_DELMAX, 16'h0000, 8'h00), 1'b0, none});
    dir_rows.push_back('{mk_op(FUNC_DELMIN, 16'h0000, 8'h00), 1'b0, none});
    dir_rows.push_back('{mk_op(FUNC_CLEAR, 16'hFFFF, 8'hFF), 1'b1,
                         mk_res(STATUS_OK, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_op(FUNC_DELMIN, 16'h0000, 8'h00), 1'b1,
                         mk_res(STATUS_EMPTY, 0, 0, 0, 0, 0, 0)});

    // hold reset, then release it
    repeat (8) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_op(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].res);

    // random bursts: fill, drain or blend, some with no idling on either side
    mix = MIX_FILL;
    burst_left = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0:       mix = MIX_FILL;
          1:       mix = MIX_DRAIN;
          default: mix = MIX_BLEND;
        endcase
        steady = ($urandom_range(0, 4) == 0);
      end
      burst_left--;
      if (n == PAUSE_AT) begin
        // hold off until the pipeline has drained
        in_valid_i <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0) @(negedge clk);
      end
      op = mk_op(pick_func(mix), pick_key(), 8'($urandom));
      send_op(op, 1'b0, none);
    end
    in_valid_i <= 1'b0;
    steady = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("ran %0d transactions: %0d insert, %0d delete-min, %0d delete-max, %0d clear",
             func_seen[0] + func_seen[1] + func_seen[2] + func_seen[3],
             func_seen[0], func_seen[1], func_seen[2], func_seen[3]);
    $display("%0d results checked, %0d full rejects, %0d empty deletes, %0d at full, peak %0d",
             n_checked, n_rejects, n_empty_dels, n_full_seen, peak_count);
    if (n_fail == 0) begin
      $display("sorted_double_ended_priority_queue verification clean");
    end else begin
      $display("sorted_double_ended_priority_queue verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/sdepq_pkg.sv
design/sdepq_cell.sv
design/sorted_double_ended_priority_queue.sv
tb/sorted_double_ended_priority_queue_tb.sv
